FILE: rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants of the Huffman tree decoder
// Holds the command codes, the queued transaction format, the result format
// and the state encoding of the execution unit.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MaxCodeBitsDef = 9;
  localparam int NodeCountDef   = 1024;
  localparam int SymW           = 8;
  localparam int CodeW          = 9;
  localparam int LenW           = 4;
  localparam int QueueDepth     = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DECODE,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [SymW-1:0] symbol;
    logic [CodeW-1:0] code;
    logic [LenW-1:0] len;
    logic            bit_in;
  } item_t;

  typedef struct packed {
    logic            symbol_valid;
    logic [SymW-1:0] symbol_out;
    logic            error;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DEC_NODE,
    B_DEC_CHILD,
    B_INS_WALK,
    B_INS_LEAF,
    B_INS_FRESH
  } back_state_t;

  // Code bits above the stored width read as zero.
  function automatic logic code_bit(input logic [CodeW-1:0] code,
                                    input logic [LenW-1:0] idx);
    logic b;
    b = 1'b0;
    for (int k = 0; k < CodeW; k++) begin
      if (LenW'(k) == idx) begin
        b = code[k];
      end
    end
    return b;
  endfunction

endpackage

FILE: rtl/htd_front.sv
// ----------------------------------------------------------------------------
// htd_front: transaction intake
// Accepts a command, saturates the code length and classifies it as an
// insert, a decode step or an insert with nothing to do.
// ----------------------------------------------------------------------------
module htd_front #(
  parameter int MAX_CODE_BITS = htd_pkg::MaxCodeBitsDef
) (
  input  logic                      start,
  input  logic                      cmd,
  input  logic [htd_pkg::SymW-1:0]  symbol,
  input  logic [htd_pkg::CodeW-1:0] code_bits,
  input  logic [htd_pkg::LenW-1:0]  code_len,
  input  logic                      bit_in,
  input  logic                      q_full,
  output logic                      busy,
  output logic                      push,
  output htd_pkg::item_t            item
);
  import htd_pkg::*;

  logic [LenW-1:0] len_sat;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    if (int'(code_len) > MAX_CODE_BITS) begin
      len_sat = LenW'(MAX_CODE_BITS);
    end else begin
      len_sat = code_len;
    end
    item.symbol = symbol;
    item.code   = code_bits;
    item.len    = len_sat;
    item.bit_in = bit_in;
    if (cmd == CMD_DECODE) begin
      item.op = OP_DECODE;
    end else if (len_sat == '0) begin
      item.op = OP_SKIP;
    end else begin
      item.op = OP_INSERT;
    end
  end

endmodule

FILE: rtl/htd_queue.sv
// ----------------------------------------------------------------------------
// htd_queue: transaction queue
// A short first-in first-out buffer of classified transactions between the
// intake and the execution unit.
// ----------------------------------------------------------------------------
module htd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htd_pkg::item_t push_item,
  input  logic           pop,
  output htd_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import htd_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            slots [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CntW'(QueueDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

FILE: rtl/htd_back.sv
// ----------------------------------------------------------------------------
// htd_back: tree execution unit
// Owns the node store, the free node counter and the decode pointer. Walks
// the tree for inserts, one node per cycle, and takes decode steps.
// ----------------------------------------------------------------------------
module htd_back #(
  parameter int NODE_COUNT = htd_pkg::NodeCountDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  htd_pkg::item_t   head,
  output logic             pop,
  output logic             done,
  output htd_pkg::result_t result
);
  import htd_pkg::*;

  localparam int IdxW  = $clog2(NODE_COUNT);
  localparam int FreeW = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [IdxW-1:0] left;
    logic [IdxW-1:0] right;
    logic            leaf;
    logic [SymW-1:0] symbol;
  } node_t;

  node_t            mem [NODE_COUNT];
  node_t            rd_data;
  node_t            node;
  node_t            wr_data;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             rd_blank;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;

  back_state_t      state, state_next;
  item_t            item, item_next;
  logic [IdxW-1:0]  cur, cur_next;
  logic [LenW-1:0]  remain, remain_next;
  logic [FreeW-1:0] next_free, next_free_next;
  logic [IdxW-1:0]  dec_ptr, dec_ptr_next;
  logic             root_valid, root_valid_next;
  logic             done_next;
  result_t          result_next;

  logic             store_full;
  logic [IdxW-1:0]  new_idx;
  logic [LenW-1:0]  step;
  logic             dir;
  logic [IdxW-1:0]  child;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // The root entry is never cleared in the store, so it reads as empty
  // until the first write to it.
  assign node       = rd_blank ? '0 : rd_data;
  assign store_full = (next_free == FreeW'(NODE_COUNT));
  assign new_idx    = IdxW'(next_free);
  assign step       = remain - 1'b1;
  assign dir        = code_bit(item.code, step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      next_free  <= FreeW'(1);
      dec_ptr    <= '0;
      root_valid <= 1'b0;
      rd_blank   <= 1'b1;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      next_free  <= next_free_next;
      dec_ptr    <= dec_ptr_next;
      root_valid <= root_valid_next;
      if (rd_en) begin
        rd_blank <= (rd_addr == '0) && !root_valid;
      end
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    cur    <= cur_next;
    remain <= remain_next;
    result <= result_next;
  end

  always_comb begin
    state_next      = state;
    item_next       = item;
    cur_next        = cur;
    remain_next     = remain;
    next_free_next  = next_free;
    dec_ptr_next    = dec_ptr;
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = cur;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = node;
    done_next       = 1'b0;
    result_next     = '0;
    child           = item.bit_in ? node.right : node.left;

    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          item_next = head;
          case (head.op)
            OP_DECODE: begin
              rd_en      = 1'b1;
              rd_addr    = dec_ptr;
              state_next = B_DEC_NODE;
            end
            OP_INSERT: begin
              rd_en       = 1'b1;
              rd_addr     = '0;
              cur_next    = '0;
              remain_next = head.len;
              state_next  = B_INS_WALK;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      B_DEC_NODE: begin
        if (child == '0) begin
          done_next         = 1'b1;
          result_next.error = 1'b1;
          dec_ptr_next      = '0;
          state_next        = B_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = child;
          cur_next   = child;
          state_next = B_DEC_CHILD;
        end
      end

      B_DEC_CHILD: begin
        done_next  = 1'b1;
        state_next = B_IDLE;
        if (node.leaf) begin
          result_next.symbol_valid = 1'b1;
          result_next.symbol_out   = node.symbol;
          dec_ptr_next             = '0;
        end else begin
          dec_ptr_next = cur;
        end
      end

      B_INS_WALK: begin
        child = dir ? node.right : node.left;
        if (child != '0) begin
          rd_en       = 1'b1;
          rd_addr     = child;
          cur_next    = child;
          remain_next = step;
          state_next  = (step == '0) ? B_INS_LEAF : B_INS_WALK;
        end else if (store_full) begin
          done_next  = 1'b1;
          state_next = B_IDLE;
        end else begin
          wr_en = 1'b1;
          if (dir) begin
            wr_data.right = new_idx;
          end else begin
            wr_data.left = new_idx;
          end
          next_free_next = next_free + 1'b1;
          cur_next       = new_idx;
          remain_next    = step;
          state_next     = B_INS_FRESH;
        end
      end

      B_INS_LEAF: begin
        wr_en          = 1'b1;
        wr_data.leaf   = 1'b1;
        wr_data.symbol = item.symbol;
        done_next      = 1'b1;
        state_next     = B_IDLE;
      end

      B_INS_FRESH: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (remain == '0) begin
          wr_data.leaf   = 1'b1;
          wr_data.symbol = item.symbol;
          done_next      = 1'b1;
          state_next     = B_IDLE;
        end else if (store_full) begin
          done_next  = 1'b1;
          state_next = B_IDLE;
        end else begin
          if (dir) begin
            wr_data.right = new_idx;
          end else begin
            wr_data.left = new_idx;
          end
          next_free_next = next_free + 1'b1;
          cur_next       = new_idx;
          remain_next    = step;
        end
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase

    root_valid_next = root_valid || (wr_en && (wr_addr == '0));
  end

endmodule

FILE: rtl/huffman_tree_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit: Huffman code tree builder and bit decoder
// Builds a binary code tree from insert transactions and decodes one bit per
// decode transaction, reporting a symbol at each leaf.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; a two-entry
// queue sits between the intake and the tree unit, so busy rises only when it
// is full. Every transaction returns exactly one result, shown for one cycle
// with done high; the receiver cannot stall it. The node store has one
// registered read port, so a decode step reads the current node, then reads
// the chosen child, then reports. A decode step that finds no child reports
// without reading a child. An insert walks one node per cycle, over as many
// nodes as the saturated code length, or fewer when the store fills up, and
// an insert with code length zero only reports. The store needs no clearing
// pass: nodes are zeroed as they are allocated.
module huffman_tree_decoder_unit #(
  parameter int MAX_CODE_BITS = htd_pkg::MaxCodeBitsDef,
  parameter int NODE_COUNT    = htd_pkg::NodeCountDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      cmd,
  input  logic [htd_pkg::SymW-1:0]  symbol,
  input  logic [htd_pkg::CodeW-1:0] code_bits,
  input  logic [htd_pkg::LenW-1:0]  code_len,
  input  logic                      bit_in,
  output logic                      busy,
  output logic                      done,
  output logic                      symbol_valid,
  output logic [htd_pkg::SymW-1:0]  symbol_out,
  output logic                      error
);
  import htd_pkg::*;

  logic    push;
  item_t   push_item;
  item_t   head;
  logic    pop;
  logic    q_empty;
  logic    q_full;
  result_t result;

  htd_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .start    (start),
    .cmd      (cmd),
    .symbol   (symbol),
    .code_bits(code_bits),
    .code_len (code_len),
    .bit_in   (bit_in),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .item     (push_item)
  );

  htd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  htd_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

  assign symbol_valid = result.symbol_valid;
  assign symbol_out   = result.symbol_out;
  assign error        = result.error;

  a_no_valid_and_error: assert property (
    @(posedge clk) disable iff (rst) done |-> !(symbol_valid && error)
  ) else $error("Result carries both a symbol and an error.");

  a_symbol_zero: assert property (
    @(posedge clk) disable iff (rst) (done && !symbol_valid) |-> (symbol_out == '0)
  ) else $error("Symbol output is not zero on a result without a symbol.");

  a_push_queued: assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |=> !q_empty
  ) else $error("Accepted transaction did not reach the queue.");

endmodule
